// File: rtl/bmtc_pkg.sv
// ----------------------------------------------------------------------------
// bmtc_pkg
// Shared types and constants of the brake motor travel controller: item
// opcodes, motor modes, event codes, register indexes and state records.
// ----------------------------------------------------------------------------
package bmtc_pkg;

	typedef enum logic [1:0] {
		OP_PIN_EDGE    = 2'd0,
		OP_DEB_TICK    = 2'd1,
		OP_TRAVEL_TICK = 2'd2,
		OP_SAMPLE      = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		MODE_BACK  = 2'd0,
		MODE_FWD   = 2'd1,
		MODE_FRONT = 2'd2,
		MODE_BWD   = 2'd3
	} mode_t;

	typedef enum logic [2:0] {
		EV_NONE        = 3'd0,
		EV_START_FWD   = 3'd1,
		EV_START_BWD   = 3'd2,
		EV_TIMEOUT     = 3'd3,
		EV_LOCK        = 3'd4,
		EV_OVERCURRENT = 3'd5
	} event_t;

	localparam int CFG_INDEX_BITS = 3;
	localparam int CFG_DATA_BITS  = 16;

	typedef logic [CFG_INDEX_BITS-1:0] cfg_index_t;

	localparam cfg_index_t CFG_DEBOUNCE_TICKS  = 3'd0;
	localparam cfg_index_t CFG_TRAVEL_TICKS    = 3'd1;
	localparam cfg_index_t CFG_LOCK_WAIT_TICKS = 3'd2;
	localparam cfg_index_t CFG_LOCK_SHIFT      = 3'd3;
	localparam cfg_index_t CFG_ALERT_LIMIT     = 3'd4;

	localparam logic [7:0]  DEBOUNCE_TICKS_RST  = 8'd5;
	localparam logic [15:0] TRAVEL_TICKS_RST    = 16'd100;
	localparam logic [15:0] LOCK_WAIT_TICKS_RST = 16'd5;
	localparam logic [3:0]  LOCK_SHIFT_RST      = 4'd2;
	localparam logic [3:0]  ALERT_LIMIT_RST     = 4'd3;

	localparam logic [3:0]  ALERT_SAT = 4'd15;

	typedef struct packed {
		logic [7:0]  debounce_ticks;
		logic [15:0] travel_ticks;
		logic [15:0] lock_wait_ticks;
		logic [3:0]  lock_shift;
		logic [3:0]  alert_limit;
	} cfg_t;

	typedef struct packed {
		mode_t       mode;
		logic        button;
		logic        deb_run;
		logic [7:0]  deb_cnt;
		logic        trav_run;
		logic [15:0] trav_cnt;
		logic [3:0]  alert_run;
	} ctrl_state_t;

	typedef struct packed {
		logic   drive_a;
		logic   drive_b;
		mode_t  motor_mode;
		logic   button;
		event_t ev;
	} result_t;

endpackage

// File: rtl/bmtc_step.sv
// ----------------------------------------------------------------------------
// bmtc_step
// Single-pass update: from the current state, the configuration and one
// item it works out the next state and the result of that item.
// ----------------------------------------------------------------------------
module bmtc_step #(
	parameter int SAMPLE_BITS = 10
) (
	input  bmtc_pkg::op_t          op,
	input  logic                   button_level,
	input  logic [SAMPLE_BITS-1:0] smp,
	input  bmtc_pkg::cfg_t         cfg,
	input  bmtc_pkg::ctrl_state_t  st,
	input  logic [SAMPLE_BITS-1:0] min_cur,
	input  logic [SAMPLE_BITS-1:0] max_cur,
	output bmtc_pkg::ctrl_state_t  st_n,
	output logic [SAMPLE_BITS-1:0] min_n,
	output logic [SAMPLE_BITS-1:0] max_n,
	output bmtc_pkg::result_t      res
);
	import bmtc_pkg::*;

	logic [7:0]           deb_inc;
	logic [15:0]          trav_inc;
	logic                 moving;
	mode_t                stop_mode;
	logic                 timeout;
	logic                 lock;
	logic [SAMPLE_BITS-1:0] smp_min;
	logic [SAMPLE_BITS-1:0] smp_max;
	logic [SAMPLE_BITS:0]   thr;
	logic                 over;
	logic [3:0]           alert_inc;
	event_t               ev;

	assign deb_inc   = st.deb_cnt + 8'd1;
	assign trav_inc  = st.trav_cnt + 16'd1;
	assign moving    = (st.mode == MODE_FWD) || (st.mode == MODE_BWD);
	assign stop_mode = (st.mode == MODE_FWD) ? MODE_FRONT : MODE_BACK;

	// timeout and lock tests on the incremented travel count
	assign timeout = (trav_inc == cfg.travel_ticks);
	assign lock    = (trav_inc >= cfg.lock_wait_ticks) &&
	                 (min_cur > (max_cur >> cfg.lock_shift));

	// running extremes, then 1.75 x minimum as the overcurrent threshold
	assign smp_min = (smp < min_cur) ? smp : min_cur;
	assign smp_max = (smp > max_cur) ? smp : max_cur;
	assign thr     = {1'b0, smp_min} + {1'b0, smp_min >> 1} + {1'b0, smp_min >> 2};
	assign over    = ({1'b0, smp} > thr);
	assign alert_inc = !over ? 4'd0 :
	                   (st.alert_run == ALERT_SAT) ? st.alert_run : st.alert_run + 4'd1;

	always_comb begin
		st_n  = st;
		min_n = min_cur;
		max_n = max_cur;
		ev    = EV_NONE;
		unique case (op)
			OP_PIN_EDGE: begin
				if (button_level != st.button) begin
					st_n.deb_run = 1'b1;
					st_n.deb_cnt = '0;
				end else begin
					st_n.deb_run = 1'b0;
				end
			end
			OP_DEB_TICK: begin
				if (st.deb_run) begin
					st_n.deb_cnt = deb_inc;
					if (deb_inc == cfg.debounce_ticks) begin
						st_n.button  = ~st.button;
						st_n.deb_run = 1'b0;
						if (!st.button && (st.mode == MODE_BACK || st.mode == MODE_BWD)) begin
							st_n.mode     = MODE_FWD;
							st_n.trav_run = 1'b1;
							st_n.trav_cnt = '0;
							min_n         = '1;
							max_n         = '0;
							ev            = EV_START_FWD;
						end else if (st.button &&
						             (st.mode == MODE_FWD || st.mode == MODE_FRONT)) begin
							st_n.mode     = MODE_BWD;
							st_n.trav_run = 1'b1;
							st_n.trav_cnt = '0;
							min_n         = '1;
							max_n         = '0;
							ev            = EV_START_BWD;
						end
					end
				end
			end
			OP_TRAVEL_TICK: begin
				if (st.trav_run) begin
					st_n.trav_cnt = trav_inc;
					if (timeout || lock) begin
						st_n.trav_run = 1'b0;
						if (moving) begin
							st_n.mode = stop_mode;
							ev        = timeout ? EV_TIMEOUT : EV_LOCK;
						end
					end
				end
			end
			OP_SAMPLE: begin
				min_n          = smp_min;
				max_n          = smp_max;
				st_n.alert_run = alert_inc;
				if (alert_inc >= cfg.alert_limit) begin
					st_n.alert_run = '0;
					if (moving) begin
						st_n.mode     = stop_mode;
						st_n.trav_run = 1'b0;
						ev            = EV_OVERCURRENT;
					end
				end
			end
			default: ;
		endcase
	end

	always_comb begin
		res.drive_a    = (st_n.mode == MODE_FWD);
		res.drive_b    = (st_n.mode == MODE_BWD);
		res.motor_mode = st_n.mode;
		res.button     = st_n.button;
		res.ev         = ev;
	end

endmodule

// File: rtl/brake_motor_travel_controller.sv
// ----------------------------------------------------------------------------
// brake_motor_travel_controller
// Four-state brake motor controller with button debounce, travel timeout,
// lock detection and overcurrent supervision.
// ----------------------------------------------------------------------------
// Each item is one of a button pin edge, a debounce tick, a travel tick or a
// current sample, and gives exactly one result. On its way to the result an
// item is caught in an input register, the whole update runs as one short
// combinational pass, and the result lands in an output register
// together with the new state. One item can be taken
// every cycle; the output register parts the two sides, so a new item is
// taken while a result still waits, and stall on the output reaches the
// input only when both registers are full. Configuration writes land at
// once and should only be made with the block idle.
module brake_motor_travel_controller #(
	parameter int SAMPLE_BITS = 10
) (
	input  logic                            clk,
	input  logic                            arst_n,
	// configuration write port
	input  logic                            cfg_we,
	input  logic [bmtc_pkg::CFG_INDEX_BITS-1:0] cfg_index,
	input  logic [bmtc_pkg::CFG_DATA_BITS-1:0]  cfg_wdata,
	// input channel
	input  logic                            in_valid,
	output logic                            in_stall,
	input  logic [1:0]                      op,
	input  logic                            button_level,
	input  logic [9:0]                      sample,
	// result channel
	output logic                            out_valid,
	input  logic                            out_stall,
	output logic                            drive_a,
	output logic                            drive_b,
	output logic [1:0]                      motor_mode,
	output logic                            button_debounced,
	output logic [2:0]                      event_res
);
	import bmtc_pkg::*;

	// configuration registers
	cfg_t cfg_q;

	// controller state
	ctrl_state_t            st_q;
	ctrl_state_t            st_n;
	logic [SAMPLE_BITS-1:0] min_q;
	logic [SAMPLE_BITS-1:0] max_q;
	logic [SAMPLE_BITS-1:0] min_n;
	logic [SAMPLE_BITS-1:0] max_n;

	// input register
	logic                   valid_s1;
	op_t                    op_s1;
	logic                   level_s1;
	logic [SAMPLE_BITS-1:0] smp_s1;

	// result register
	logic                   out_valid_q;
	result_t                res;
	result_t                res_q;

	logic                   advance;
	logic                   in_take;

	// item in the input register moves on when the result slot is free
	assign advance  = valid_s1 && (!out_valid_q || !out_stall);
	assign in_stall = valid_s1 && !advance;
	assign in_take  = in_valid && !in_stall;

	// configuration writes, indexes beyond the list are dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.debounce_ticks  <= DEBOUNCE_TICKS_RST;
			cfg_q.travel_ticks    <= TRAVEL_TICKS_RST;
			cfg_q.lock_wait_ticks <= LOCK_WAIT_TICKS_RST;
			cfg_q.lock_shift      <= LOCK_SHIFT_RST;
			cfg_q.alert_limit     <= ALERT_LIMIT_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_DEBOUNCE_TICKS:  cfg_q.debounce_ticks  <= cfg_wdata[7:0];
				CFG_TRAVEL_TICKS:    cfg_q.travel_ticks    <= cfg_wdata;
				CFG_LOCK_WAIT_TICKS: cfg_q.lock_wait_ticks <= cfg_wdata;
				CFG_LOCK_SHIFT:      cfg_q.lock_shift      <= cfg_wdata[3:0];
				CFG_ALERT_LIMIT:     cfg_q.alert_limit     <= cfg_wdata[3:0];
				default: ;
			endcase
		end
	end

	// input register: sample taken in its low SAMPLE_BITS bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_take) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_take) begin
			op_s1    <= op_t'(op);
			level_s1 <= button_level;
			smp_s1   <= SAMPLE_BITS'(sample);
		end
	end

	bmtc_step #(
		.SAMPLE_BITS(SAMPLE_BITS)
	) u_step (
		.op          (op_s1),
		.button_level(level_s1),
		.smp         (smp_s1),
		.cfg         (cfg_q),
		.st          (st_q),
		.min_cur     (min_q),
		.max_cur     (max_q),
		.st_n        (st_n),
		.min_n       (min_n),
		.max_n       (max_n),
		.res         (res)
	);

	// state commits as the item leaves the input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q.mode      <= MODE_BACK;
			st_q.button    <= 1'b0;
			st_q.deb_run   <= 1'b0;
			st_q.deb_cnt   <= '0;
			st_q.trav_run  <= 1'b0;
			st_q.trav_cnt  <= '0;
			st_q.alert_run <= '0;
			min_q          <= '0;
			max_q          <= '0;
		end else if (advance) begin
			st_q  <= st_n;
			min_q <= min_n;
			max_q <= max_n;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			res_q <= res;
		end
	end

	assign out_valid        = out_valid_q;
	assign drive_a          = res_q.drive_a;
	assign drive_b          = res_q.drive_b;
	assign motor_mode       = res_q.motor_mode;
	assign button_debounced = res_q.button;
	assign event_res        = res_q.ev;

	// travel timing only runs while the motor is moving
	a_trav_moving: assert property (@(posedge clk) disable iff (!arst_n)
		st_q.trav_run |-> (st_q.mode == MODE_FWD || st_q.mode == MODE_BWD))
		else $error("travel timing running while motor stopped");

	// a forward start always reports forward movement
	a_start_fwd: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && res_q.ev == EV_START_FWD) |-> (res_q.motor_mode == MODE_FWD))
		else $error("forward start without forward mode");

	// committed mode matches the mode shown with the latest result
	a_mode_commit: assert property (@(posedge clk) disable iff (!arst_n)
		advance |=> (res_q.motor_mode == st_q.mode))
		else $error("result mode differs from committed mode");

	// input side only stalls on a full pipe
	a_stall_full: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> (valid_s1 && out_valid_q && out_stall))
		else $error("input stalled with room in the pipe");

endmodule

// File: bench/bmtc_tb_pkg.sv
// ----------------------------------------------------------------------------
// bmtc_tb_pkg
// Result tracker for the brake motor travel controller bench: keeps its own
// copy of the controller state and settings, works out the result of every
// accepted item and compares the results that come back in order.
// ----------------------------------------------------------------------------
package bmtc_tb_pkg;

	import bmtc_pkg::*;

	class travel_tracker;

		// settings
		logic [7:0]  deb_ticks;
		logic [15:0] trav_ticks;
		logic [15:0] lock_wait;
		logic [3:0]  lock_shift;
		logic [3:0]  alert_limit;

		// controller state
		mode_t       mode;
		logic        button;
		logic        deb_run;
		logic [7:0]  deb_cnt;
		logic        trav_run;
		logic [15:0] trav_cnt;
		logic [9:0]  min_cur;
		logic [9:0]  max_cur;
		logic [3:0]  alert_run;

		result_t     pending_results[$];
		int          mismatches;
		int          results_seen;
		int          event_tally[6];

		function new();
			deb_ticks   = DEBOUNCE_TICKS_RST;
			trav_ticks  = TRAVEL_TICKS_RST;
			lock_wait   = LOCK_WAIT_TICKS_RST;
			lock_shift  = LOCK_SHIFT_RST;
			alert_limit = ALERT_LIMIT_RST;
			mode        = MODE_BACK;
			button      = 1'b0;
			deb_run     = 1'b0;
			deb_cnt     = '0;
			trav_run    = 1'b0;
			trav_cnt    = '0;
			min_cur     = '0;
			max_cur     = '0;
			alert_run   = '0;
			mismatches  = 0;
			results_seen = 0;
			foreach (event_tally[i]) event_tally[i] = 0;
		endfunction

		function void set_reg(cfg_index_t idx, logic [15:0] value);
			case (idx)
				CFG_DEBOUNCE_TICKS:  deb_ticks   = value[7:0];
				CFG_TRAVEL_TICKS:    trav_ticks  = value;
				CFG_LOCK_WAIT_TICKS: lock_wait   = value;
				CFG_LOCK_SHIFT:      lock_shift  = value[3:0];
				CFG_ALERT_LIMIT:     alert_limit = value[3:0];
				default: ;
			endcase
		endfunction

		function int pending();
			return pending_results.size();
		endfunction

		function event_t start_move(mode_t target);
			mode     = target;
			trav_run = 1'b1;
			trav_cnt = '0;
			min_cur  = '1;
			max_cur  = '0;
			return (target == MODE_FWD) ? EV_START_FWD : EV_START_BWD;
		endfunction

		// only a moving motor stops
		function event_t stop_move(event_t why);
			if (mode == MODE_FWD) begin
				mode = MODE_FRONT;
			end else if (mode == MODE_BWD) begin
				mode = MODE_BACK;
			end else begin
				return EV_NONE;
			end
			trav_run = 1'b0;
			return why;
		endfunction

		// returns 1 for a debounce or travel tick with nothing running
		function bit note_item(op_t code, logic level, logic [9:0] smp);
			event_t      ev;
			event_t      lock_ev;
			logic [11:0] thr;
			bit          ignored;
			result_t     r;
			ev      = EV_NONE;
			ignored = 1'b0;
			case (code)
				OP_PIN_EDGE: begin
					if (level != button) begin
						deb_run = 1'b1;
						deb_cnt = '0;
					end else begin
						deb_run = 1'b0;
					end
				end
				OP_DEB_TICK: begin
					if (!deb_run) begin
						ignored = 1'b1;
					end else begin
						deb_cnt = deb_cnt + 8'd1;
						if (deb_cnt == deb_ticks) begin
							button = ~button;
							if (button) begin
								if (mode == MODE_BACK || mode == MODE_BWD) ev = start_move(MODE_FWD);
							end else begin
								if (mode == MODE_FWD || mode == MODE_FRONT) ev = start_move(MODE_BWD);
							end
							deb_run = 1'b0;
						end
					end
				end
				OP_TRAVEL_TICK: begin
					if (!trav_run) begin
						ignored = 1'b1;
					end else begin
						trav_cnt = trav_cnt + 16'd1;
						if (trav_cnt == trav_ticks) begin
							ev       = stop_move(EV_TIMEOUT);
							trav_run = 1'b0;
						end
						// a timeout in the same tick wins
						if (trav_cnt >= lock_wait && min_cur > (max_cur >> lock_shift)) begin
							lock_ev = stop_move(EV_LOCK);
							if (ev == EV_NONE) ev = lock_ev;
							trav_run = 1'b0;
						end
					end
				end
				default: begin
					if (smp < min_cur) min_cur = smp;
					if (smp > max_cur) max_cur = smp;
					thr = {2'b00, min_cur} + (min_cur >> 1) + (min_cur >> 2);
					if ({2'b00, smp} > thr) begin
						if (alert_run != ALERT_SAT) alert_run = alert_run + 4'd1;
					end else begin
						alert_run = '0;
					end
					if (alert_run >= alert_limit) begin
						ev        = stop_move(EV_OVERCURRENT);
						alert_run = '0;
					end
				end
			endcase
			r.drive_a    = (mode == MODE_FWD);
			r.drive_b    = (mode == MODE_BWD);
			r.motor_mode = mode;
			r.button     = button;
			r.ev         = ev;
			pending_results.push_back(r);
			event_tally[int'(ev)]++;
			return ignored;
		endfunction

		function void report(string what, logic [2:0] want, logic [2:0] got);
			if (want !== got) begin
				mismatches++;
				if (mismatches <= 10)
					$display("%0t mismatch on %s: expected %0d, got %0d", $time, what, want, got);
			end
		endfunction

		function void check_result(result_t got);
			result_t want;
			results_seen++;
			if (pending_results.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("%0t result with nothing expected: %b", $time, got);
				return;
			end
			want = pending_results.pop_front();
			report("drive_a", want.drive_a, got.drive_a);
			report("drive_b", want.drive_b, got.drive_b);
			report("motor_mode", want.motor_mode, got.motor_mode);
			report("button_debounced", want.button, got.button);
			report("event_res", want.ev, got.ev);
		endfunction

	endclass

endpackage

// File: bench/tb_brake_motor_travel_controller.sv
// ----------------------------------------------------------------------------
// tb_brake_motor_travel_controller
// Drives button edges, debounce and travel ticks and current samples into
// the brake motor travel controller under several register settings and
// random idling on both channels, and checks every result against the
// tracker's own prediction of the controller.
// ----------------------------------------------------------------------------
module tb_brake_motor_travel_controller;

	timeunit 1ns;
	timeprecision 1ps;

	import bmtc_pkg::*;
	import bmtc_tb_pkg::*;

	localparam int HOLD_CYCLES  = 60;  // long receiver hold-off
	localparam int DRAIN_CYCLES = 4;   // input and result registers plus margin

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       cfg_we = 1'b0;
	cfg_index_t cfg_index = '0;
	logic [CFG_DATA_BITS-1:0] cfg_wdata = '0;
	logic       in_valid = 1'b0;
	logic       in_stall;
	logic [1:0] op = '0;
	logic       button_level = 1'b0;
	logic [9:0] sample = '0;
	logic       out_valid;
	logic       out_stall = 1'b0;
	logic       drive_a;
	logic       drive_b;
	logic [1:0] motor_mode;
	logic       button_debounced;
	logic [2:0] event_res;

	travel_tracker tracker;

	int idle_mode = 0;     // 0: sender 36 / receiver 76, 1: swapped, 2: no idling
	int hold_req = 0;      // bumped by the stimulus to ask for a hold-off
	int hold_seen = 0;
	int hold_left = 0;
	int useful_items = 0;  // transfers that the block does not simply ignore

	brake_motor_travel_controller dut (
		.clk              (clk),
		.arst_n           (arst_n),
		.cfg_we           (cfg_we),
		.cfg_index        (cfg_index),
		.cfg_wdata        (cfg_wdata),
		.in_valid         (in_valid),
		.in_stall         (in_stall),
		.op               (op),
		.button_level     (button_level),
		.sample           (sample),
		.out_valid        (out_valid),
		.out_stall        (out_stall),
		.drive_a          (drive_a),
		.drive_b          (drive_b),
		.motor_mode       (motor_mode),
		.button_debounced (button_debounced),
		.event_res        (event_res)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// result side: check each transfer, then pick the stall for the next cycle
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall)
			tracker.check_result({drive_a, drive_b, motor_mode, button_debounced, event_res});
		if (hold_req != hold_seen) begin
			hold_seen = hold_req;
			hold_left = HOLD_CYCLES;
		end
		if (hold_left > 0) begin
			// long hold-off so the block fills up and stalls its input
			hold_left--;
			out_stall <= 1'b1;
		end else begin
			case (idle_mode)
				0:       out_stall <= ($urandom_range(0, 99) < 76);
				1:       out_stall <= ($urandom_range(0, 99) < 36);
				default: out_stall <= 1'b0;
			endcase
		end
	end

	function automatic bit sender_idles();
		case (idle_mode)
			0:       return $urandom_range(0, 99) < 36;
			1:       return $urandom_range(0, 99) < 76;
			default: return 1'b0;
		endcase
	endfunction

	// one input transfer; the payload holds while stalled
	task automatic send_item(op_t code, logic level, logic [9:0] smp);
		while (sender_idles()) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid     <= 1'b1;
		op           <= code;
		button_level <= level;
		sample       <= smp;
		do @(posedge clk); while (in_stall);
		if (!tracker.note_item(code, level, smp)) useful_items++;
	endtask

	// wait until every expected result is back and the pipeline is empty
	task automatic drain();
		in_valid <= 1'b0;
		while (tracker.pending() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(cfg_index_t idx, logic [15:0] value);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= value;
		@(posedge clk);
		tracker.set_reg(idx, value);
	endtask

	// registers only change with the block idle
	task automatic apply_settings(logic [7:0] deb, logic [15:0] trav, logic [15:0] wait_ticks,
			logic [3:0] shift, logic [3:0] alert);
		drain();
		write_reg(CFG_DEBOUNCE_TICKS, {8'd0, deb});
		write_reg(CFG_TRAVEL_TICKS, trav);
		write_reg(CFG_LOCK_WAIT_TICKS, wait_ticks);
		write_reg(CFG_LOCK_SHIFT, {12'd0, shift});
		write_reg(CFG_ALERT_LIMIT, {12'd0, alert});
		cfg_we <= 1'b0;
	endtask

	// button press or release, optionally with contact bounce first
	task automatic press(int bounces);
		logic target;
		int   short_max;
		int   full;
		target    = ~tracker.button;
		short_max = (tracker.deb_ticks > 4) ? 3 : int'(tracker.deb_ticks) - 1;
		repeat (bounces) begin
			send_item(OP_PIN_EDGE, target, 10'($urandom_range(0, 1023)));
			repeat ($urandom_range(0, short_max))
				send_item(OP_DEB_TICK, 1'($urandom), 10'($urandom_range(0, 1023)));
			// bounce back to the old level stops the debounce
			send_item(OP_PIN_EDGE, ~target, 10'($urandom_range(0, 1023)));
		end
		send_item(OP_PIN_EDGE, target, 10'($urandom_range(0, 1023)));
		full = tracker.deb_ticks;
		// now and then the press is cut short
		if ($urandom_range(0, 99) < 10) full = $urandom_range(0, full - 1);
		repeat (full) send_item(OP_DEB_TICK, 1'($urandom), 10'($urandom_range(0, 1023)));
	endtask

	// travel ticks mixed with current samples around a base level
	task automatic move_burst(int len);
		int base;
		int r;
		int v;
		base = $urandom_range(8, 600);
		repeat (len) begin
			if ($urandom_range(0, 99) < 45) begin
				send_item(OP_TRAVEL_TICK, 1'($urandom), 10'($urandom_range(0, 1023)));
			end else begin
				r = $urandom_range(0, 99);
				if (r < 60)      v = base + $urandom_range(0, base / 4);
				else if (r < 80) v = 2 * base + $urandom_range(0, 64);   // overcurrent spike
				else if (r < 90) v = $urandom_range(0, 1023);
				else             v = base / 2;                            // dip pulls the minimum
				if (v > 1023) v = 1023;
				send_item(OP_SAMPLE, 1'($urandom), 10'(v));
			end
		end
	endtask

	task automatic random_traffic(int n);
		int goal;
		int r;
		goal = useful_items + n;
		while (useful_items < goal) begin
			r = $urandom_range(0, 99);
			if (r < 30)      press($urandom_range(0, 2));
			else if (r < 85) move_burst($urandom_range(4, 20));
			else             send_item(op_t'($urandom_range(0, 3)), 1'($urandom),
					10'($urandom_range(0, 1023)));
		end
	endtask

	task automatic directed();
		// samples while stopped, extremes of the sample field; third high one
		// reaches the alert limit but only clears the run
		send_item(OP_SAMPLE, 1'b0, 10'd0);
		repeat (3) send_item(OP_SAMPLE, 1'b1, 10'd1023);
		// ticks with nothing running are ignored
		send_item(OP_DEB_TICK, 1'b0, 10'd0);
		send_item(OP_TRAVEL_TICK, 1'b1, 10'd1023);
		// edge to the current level, then a real press
		send_item(OP_PIN_EDGE, 1'b0, 10'd0);
		send_item(OP_PIN_EDGE, 1'b1, 10'd0);
		repeat (5) send_item(OP_DEB_TICK, 1'b0, 10'd0);
		// no samples since the start: lock fires once the wait has passed
		repeat (5) send_item(OP_TRAVEL_TICK, 1'b0, 10'd0);
		// short travel where timeout and lock fall on the same tick
		apply_settings(8'd1, 16'd2, 16'd2, 4'd2, 4'd1);
		send_item(OP_PIN_EDGE, 1'b0, 10'd0);
		send_item(OP_DEB_TICK, 1'b0, 10'd0);
		repeat (2) send_item(OP_TRAVEL_TICK, 1'b0, 10'd0);
		// forward start, then one overcurrent sample stops it
		send_item(OP_PIN_EDGE, 1'b1, 10'd0);
		send_item(OP_DEB_TICK, 1'b0, 10'd0);
		send_item(OP_SAMPLE, 1'b0, 10'd100);
		send_item(OP_SAMPLE, 1'b0, 10'd400);
	endtask

	initial begin
		tracker = new();
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset settings, then the low extremes
		idle_mode = 0;
		directed();
		apply_settings(8'd1, 16'd1, 16'd0, 4'd0, 4'd1);
		random_traffic(60);
		apply_settings(8'd3, 16'd20, 16'd4, 4'd2, 4'd3);
		random_traffic(80);

		// lock never armed, high shift and alert limit; then no timeout
		idle_mode = 1;
		apply_settings(8'd2, 16'd30, 16'd65535, 4'd15, 4'd15);
		random_traffic(70);
		apply_settings(8'd4, 16'd65535, 16'd6, 4'd1, 4'd2);
		random_traffic(80);

		// longest debounce: one press only
		idle_mode = 2;
		apply_settings(8'd255, 16'd12, 16'd2, 4'd3, 4'd4);
		press(0);
		move_burst(20);

		// receiver holds off while items keep coming
		apply_settings(8'd2, 16'd15, 16'd3, 4'd2, 4'd2);
		hold_req <= hold_req + 1;
		random_traffic(70);

		drain();
		$display("checked %0d results of %0d effective transfers under 8 register settings",
			tracker.results_seen, useful_items);
		$display("starts fwd/bwd %0d/%0d, stops timeout/lock/overcurrent %0d/%0d/%0d",
			tracker.event_tally[EV_START_FWD], tracker.event_tally[EV_START_BWD],
			tracker.event_tally[EV_TIMEOUT], tracker.event_tally[EV_LOCK],
			tracker.event_tally[EV_OVERCURRENT]);
		if (tracker.mismatches == 0 && tracker.pending() == 0) begin
			$display("Simulation PASSED");
		end else begin
			$display("%0d mismatches", tracker.mismatches);
			$display("Simulation FAILED");
		end
		$finish;
	end

	// watchdog
	initial begin
		#2_000_000;
		$display("timeout with %0d results outstanding", tracker.pending());
		$display("Simulation FAILED");
		$finish;
	end

endmodule

// File: sim.f
rtl/bmtc_pkg.sv
rtl/bmtc_step.sv
rtl/brake_motor_travel_controller.sv
bench/bmtc_tb_pkg.sv
bench/tb_brake_motor_travel_controller.sv
